>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/qpr_pkg.sv
package qpr_pkg;

  localparam int COEF_WIDTH    = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ROOT_WIDTH    = 33;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
    logic signed [COEF_WIDTH-1:0] coef_c;
  } eq_t;

  typedef struct packed {
    logic signed [ROOT_WIDTH-1:0] root_value;
    logic                         root_valid;
  } sol_t;

endpackage

>>> rtl/qpr_sqrt.sv
module qpr_sqrt #(
  parameter int ROOT_W = 33,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  src_valid,
  input  logic [2*ROOT_W-1:0]   src_x,
  input  logic [SIDE_W-1:0]     src_side,
  output logic                  dst_valid,
  output logic [ROOT_W-1:0]     dst_root,
  output logic [SIDE_W-1:0]     dst_side
);

  localparam int REM_W = ROOT_W + 2;

  logic                valid [ROOT_W+1];
  logic [REM_W-1:0]    rem   [ROOT_W];
  logic [ROOT_W-1:0]   root  [ROOT_W+1];
  logic [2*ROOT_W-1:0] x     [ROOT_W];
  logic [SIDE_W-1:0]   side  [ROOT_W+1];

  assign valid[0] = src_valid;
  assign rem[0]   = '0;
  assign root[0]  = '0;
  assign x[0]     = src_x;
  assign side[0]  = src_side;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             fits;

    assign rem_sh = {rem[k][REM_W-3:0], x[k][2*ROOT_W-1 -: 2]};
    assign trial  = {root[k], 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else if (en) begin
        valid[k+1] <= valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root[k+1] <= {root[k][ROOT_W-2:0], fits};
        side[k+1] <= side[k];
      end
    end

    if (k < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= fits ? rem_sh - trial : rem_sh;
          x[k+1]   <= x[k] << 2;
        end
      end
    end
  end

  assign dst_valid = valid[ROOT_W];
  assign dst_root  = root[ROOT_W];
  assign dst_side  = side[ROOT_W];

endmodule

>>> rtl/qpr_div.sv
module qpr_div #(
  parameter int NUM_W  = 34,
  parameter int DEN_W  = 17,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              src_valid,
  input  logic [NUM_W-1:0]  src_num,
  input  logic [DEN_W-1:0]  src_den,
  input  logic [SIDE_W-1:0] src_side,
  output logic              dst_valid,
  output logic [NUM_W-1:0]  dst_quo,
  output logic [SIDE_W-1:0] dst_side
);

  localparam int REM_W = DEN_W + 1;

  logic              valid [NUM_W+1];
  logic [DEN_W-1:0]  rem   [NUM_W];
  logic [DEN_W-1:0]  den   [NUM_W];
  logic [NUM_W-1:0]  num   [NUM_W+1];
  logic [SIDE_W-1:0] side  [NUM_W+1];

  assign valid[0] = src_valid;
  assign rem[0]   = '0;
  assign den[0]   = src_den;
  assign num[0]   = src_num;
  assign side[0]  = src_side;

  for (genvar k = 0; k < NUM_W; k++) begin : g_step
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] diff;
    logic             fits;

    assign rem_sh = {rem[k], num[k][NUM_W-1]};
    assign diff   = rem_sh - {1'b0, den[k]};
    assign fits   = rem_sh >= {1'b0, den[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else if (en) begin
        valid[k+1] <= valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num[k+1]  <= {num[k][NUM_W-2:0], fits};
        side[k+1] <= side[k];
      end
    end

    if (k < NUM_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
          den[k+1] <= den[k];
        end
      end
    end
  end

  assign dst_valid = valid[NUM_W];
  assign dst_quo   = num[NUM_W];
  assign dst_side  = side[NUM_W];

endmodule

>>> rtl/quadratic_positive_root.sv
// Throughput: one transaction per cycle while the result is not stalled; the square root and the divide each
// resolve one result bit per pipeline stage.
// Backpressure on the result freezes the whole pipeline in place.
// Reset clears the stage valid bits and the result valid; data registers are not reset.
`include "assert_macros.svh"

module quadratic_positive_root #(
  parameter int FRAC_BITS = qpr_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          eq_valid,
  output logic          eq_stall,
  input  qpr_pkg::eq_t  eq,
  output logic          sol_valid,
  input  logic          sol_stall,
  output qpr_pkg::sol_t sol
);

  import qpr_pkg::*;

  localparam int W      = COEF_WIDTH;
  localparam int DW     = 2 * W + 1;
  localparam int SQ_W   = W + FRAC_BITS + 1;
  localparam int BF_W   = W + FRAC_BITS;
  localparam int NW     = W + FRAC_BITS + 2;
  localparam int DEN_W  = W + 1;
  localparam int QX     = (NW > ROOT_WIDTH) ? NW : ROOT_WIDTH;
  localparam int SQ_SIDE = 2 * W + 3;

  logic en;

  assign en       = !(sol_valid && sol_stall);
  assign eq_stall = !en;

  // stage 1: magnitudes and signs
  logic [W-1:0] ua, ub, uc;
  logic         s1_valid;
  logic [W-1:0] s1_ma, s1_mb, s1_mc;
  logic         s1_na, s1_nb, s1_nc;

  assign ua = eq.coef_a;
  assign ub = eq.coef_b;
  assign uc = eq.coef_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= eq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ma <= ua[W-1] ? ~ua + 1'b1 : ua;
      s1_mb <= ub[W-1] ? ~ub + 1'b1 : ub;
      s1_mc <= uc[W-1] ? ~uc + 1'b1 : uc;
      s1_na <= ua[W-1];
      s1_nb <= ub[W-1];
      s1_nc <= uc[W-1];
    end
  end

  // stage 2: products
  logic [2*W-1:0] bb, ac;
  logic           s2_valid;
  logic [2*W-1:0] s2_bb, s2_ac;
  logic [W-1:0]   s2_ma, s2_mb;
  logic           s2_na, s2_nb, s2_nac;

  assign bb = s1_mb * s1_mb;
  assign ac = s1_ma * s1_mc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_bb  <= bb;
      s2_ac  <= ac;
      s2_ma  <= s1_ma;
      s2_mb  <= s1_mb;
      s2_na  <= s1_na;
      s2_nb  <= s1_nb;
      s2_nac <= s1_na ^ s1_nc;
    end
  end

  // stage 3: discriminant
  logic [2*W+1:0] ac4, bb_x, d_sum, d_dif;
  logic           neg4ac;
  logic           s3_valid;
  logic [DW-1:0]  s3_d;
  logic           s3_ok;
  logic [W-1:0]   s3_ma, s3_mb;
  logic           s3_na, s3_nb;

  assign ac4    = {s2_ac, 2'b00};
  assign bb_x   = (2*W+2)'(s2_bb);
  assign d_sum  = bb_x + ac4;
  assign d_dif  = bb_x - ac4;
  assign neg4ac = (s2_ac != '0) && s2_nac;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_d  <= neg4ac ? d_sum[DW-1:0] : d_dif[DW-1:0];
      s3_ok <= (s2_ma != '0) && (neg4ac || (ac4 <= bb_x));
      s3_ma <= s2_ma;
      s3_mb <= s2_mb;
      s3_na <= s2_na;
      s3_nb <= s2_nb;
    end
  end

  // square root of the scaled discriminant
  logic [2*SQ_W-1:0] sq_x;
  logic              sq_valid;
  logic [SQ_W-1:0]   sq_root;
  logic [SQ_SIDE-1:0] sq_side;
  logic [W-1:0]      sq_ma, sq_mb;
  logic              sq_na, sq_nb, sq_ok;

  assign sq_x = (2*SQ_W)'(s3_d) << (2 * FRAC_BITS);

  qpr_sqrt #(
    .ROOT_W (SQ_W),
    .SIDE_W (SQ_SIDE)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .src_valid (s3_valid),
    .src_x     (sq_x),
    .src_side  ({s3_ma, s3_mb, s3_na, s3_nb, s3_ok}),
    .dst_valid (sq_valid),
    .dst_root  (sq_root),
    .dst_side  (sq_side)
  );

  assign {sq_ma, sq_mb, sq_na, sq_nb, sq_ok} = sq_side;

  // stage 4: numerator -b + sqrt(D)
  logic [NW-1:0]    s_x, bf_x;
  logic [BF_W-1:0]  bf;
  logic             s_ge;
  logic             s4_valid;
  logic [NW-1:0]    s4_num;
  logic [DEN_W-1:0] s4_den;
  logic             s4_neg, s4_ok;

  assign bf   = BF_W'(sq_mb) << FRAC_BITS;
  assign s_x  = NW'(sq_root);
  assign bf_x = NW'(bf);
  assign s_ge = s_x >= bf_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sq_nb) begin
        s4_num <= s_x + bf_x;
      end else if (s_ge) begin
        s4_num <= s_x - bf_x;
      end else begin
        s4_num <= bf_x - s_x;
      end
      s4_neg <= (!sq_nb && !s_ge) ^ sq_na;
      s4_den <= {sq_ma, 1'b0};
      s4_ok  <= sq_ok;
    end
  end

  // divide by 2a
  logic          dv_valid;
  logic [NW-1:0] dv_quo;
  logic          dv_neg, dv_ok;

  qpr_div #(
    .NUM_W  (NW),
    .DEN_W  (DEN_W),
    .SIDE_W (2)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .src_valid (s4_valid),
    .src_num   (s4_num),
    .src_den   (s4_den),
    .src_side  ({s4_neg, s4_ok}),
    .dst_valid (dv_valid),
    .dst_quo   (dv_quo),
    .dst_side  ({dv_neg, dv_ok})
  );

  // output register: apply sign, zero the value of invalid results
  logic [QX-1:0] q_x, q_s;

  assign q_x = QX'(dv_quo);
  assign q_s = dv_neg ? ~q_x + 1'b1 : q_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      sol_valid <= 1'b0;
    end else if (en) begin
      sol_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sol.root_value <= dv_ok ? q_s[ROOT_WIDTH-1:0] : '0;
      sol.root_valid <= dv_ok;
    end
  end

  `ASSERT_NOW(a_stall_from_output, eq_stall, sol_valid && sol_stall,
    "input stall without output backpressure")
  `ASSERT_NOW(a_invalid_is_zero, sol_valid && !sol.root_valid, sol.root_value == '0,
    "invalid root carries a nonzero value")
  `ASSERT_NEXT(a_freeze_holds, !en, $stable(s4_valid) && $stable(s4_num),
    "numerator stage moved while frozen")

endmodule
